// ===== src/cctb_pkg.sv =====
// ----------------------------------------------------------------------------
// cctb_pkg: shared types and constants of the character class table builder
// Item codes, result codes, the command word that runs from the text decoder
// to the table engine, and the fixed field widths of the channels.
// ----------------------------------------------------------------------------
`default_nettype none

package cctb_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int MASK_BITS_DEF     = 64;

  localparam int CH_W    = 8;
  localparam int CBIT_W  = 6;
  localparam int MASK_W  = 64;
  localparam int ENTRY_W = 64;

  localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CH_W-1:0] CH_DASH   = 8'h2D;
  localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_EOL  = 2'd1,
    MODE_READ = 2'd2,
    MODE_EXCL = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FINISHED = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_APPLY = 2'd1,
    CMD_READ  = 2'd2,
    CMD_EXCL  = 2'd3
  } cmd_kind_t;

  // One command per accepted item. For an apply, lo..hi is the range (hi is
  // never below lo) and dash_too adds a second single-entry update at '-'.
  // For a read, lo is the table index.
  typedef struct packed {
    cmd_kind_t          kind;
    status_t            status;
    logic [CH_W-1:0]    lo;
    logic [CH_W-1:0]    hi;
    logic               dash_too;
    logic [CBIT_W-1:0]  cbit;
    logic               rem;
    logic [MASK_W-1:0]  mask;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/cctb_if.sv =====
// ----------------------------------------------------------------------------
// cctb_if: item and result channels of the character class table builder
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface cctb_in_if import cctb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [CH_W-1:0]    ch;
  logic [CBIT_W-1:0]  class_bit;
  logic               remove_bits;
  logic [MASK_W-1:0]  other_mask;

  modport source (output valid, output mode, output ch, output class_bit,
                  output remove_bits, output other_mask, input ready);
  modport sink   (input valid, input mode, input ch, input class_bit,
                  input remove_bits, input other_mask, output ready);
endinterface

interface cctb_out_if import cctb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [ENTRY_W-1:0] entry;

  modport source (output valid, output status, output entry, input ready);
  modport sink   (input valid, input status, input entry, output ready);
endinterface

`default_nettype wire

// ===== src/cctb_front.sv =====
// ----------------------------------------------------------------------------
// cctb_front: escape decoder and range builder
// Takes one item per cycle while the queue has room, runs the escape and range
// parser, and turns each item into one table command with its result status.
// ----------------------------------------------------------------------------
`default_nettype none

module cctb_front import cctb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  cctb_in_if.sink    item,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_ready
);

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_ESC   = 6'b000010,
    PH_OCT   = 6'b000100,
    PH_HEX0  = 6'b001000,
    PH_HEX1  = 6'b010000,
    PH_AFTER = 6'b100000
  } phase_t;

  function automatic logic [4:0] hex_digit(input logic [CH_W-1:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic cmd_t set_apply(input cmd_t base, input logic [CH_W-1:0] lo,
                                     input logic [CH_W-1:0] hi, input logic two);
    cmd_t r;
    r          = base;
    r.kind     = CMD_APPLY;
    r.lo       = lo;
    r.hi       = (hi < lo) ? lo : hi;
    r.dash_too = two;
    return r;
  endfunction

  phase_t          phase, phase_next;
  logic [CH_W-1:0] held, held_next;
  logic [8:0]      dval, dval_next;
  logic [1:0]      dcnt, dcnt_next;
  logic            dash, dash_next;
  logic            err, err_next;

  logic [CH_W-1:0] c;
  logic            acc;
  logic [4:0]      hx;
  logic [8:0]      oct_val;
  logic [1:0]      oct_cnt;
  logic            is_oct;

  cmd_t            base;
  logic            raise, dlv, flush, in_after, in_idle, id_dash;
  logic [CH_W-1:0] dlv_v, fv, ah, id_held;

  assign c         = item.ch;
  assign acc       = item.valid && cmd_ready;
  assign hx        = hex_digit(c);
  assign oct_val   = {dval[5:0], c[2:0]};
  assign oct_cnt   = dcnt + 2'd1;
  assign is_oct    = (c >= 8'h30) && (c <= 8'h37);
  assign cmd_valid = item.valid;
  assign item.ready = cmd_ready;

  always_comb begin
    phase_next = phase;
    held_next  = held;
    dval_next  = dval;
    dcnt_next  = dcnt;
    dash_next  = dash;
    err_next   = err;

    base          = '0;
    base.kind     = CMD_NONE;
    base.status   = ST_ACCEPTED;
    base.lo       = c;
    base.hi       = c;
    base.cbit     = item.class_bit;
    base.rem      = item.remove_bits;
    base.mask     = item.other_mask;
    cmd           = base;

    raise    = 1'b0;
    dlv      = 1'b0;
    dlv_v    = '0;
    flush    = 1'b0;
    fv       = '0;
    in_after = 1'b0;
    ah       = '0;
    in_idle  = 1'b0;
    id_dash  = 1'b0;
    id_held  = '0;

    unique case (item.mode)
      MODE_TEXT: begin
        if (err) begin
          cmd.status = ST_INVALID;
        end else begin
          dval_next = '0;
          dcnt_next = '0;
          unique case (phase)
            PH_IDLE: begin
              in_idle = 1'b1;
              id_dash = dash;
              id_held = held;
            end
            PH_ESC: begin
              unique case (c) inside
                CH_BSLASH: begin dlv = 1'b1; dlv_v = CH_BSLASH; end
                CH_QUOTE:  begin dlv = 1'b1; dlv_v = CH_QUOTE; end
                8'h61:     begin dlv = 1'b1; dlv_v = 8'd7; end
                8'h62:     begin dlv = 1'b1; dlv_v = 8'd8; end
                8'h74:     begin dlv = 1'b1; dlv_v = 8'd9; end
                8'h6E:     begin dlv = 1'b1; dlv_v = 8'd10; end
                8'h76:     begin dlv = 1'b1; dlv_v = 8'd11; end
                8'h66:     begin dlv = 1'b1; dlv_v = 8'd12; end
                8'h72:     begin dlv = 1'b1; dlv_v = 8'd13; end
                8'h78, 8'h58: begin
                  phase_next = PH_HEX0;
                end
                [8'h30:8'h37]: begin
                  dval_next  = {6'b0, c[2:0]};
                  dcnt_next  = 2'd1;
                  phase_next = PH_OCT;
                end
                default: raise = 1'b1;
              endcase
            end
            PH_OCT: begin
              if (is_oct) begin
                if (oct_cnt == 2'd3) begin
                  if (oct_val[8]) begin
                    raise = 1'b1;
                  end else begin
                    dlv   = 1'b1;
                    dlv_v = oct_val[7:0];
                  end
                end else begin
                  dval_next = oct_val;
                  dcnt_next = oct_cnt;
                end
              end else begin
                flush = 1'b1;
                fv    = dval[7:0];
              end
            end
            PH_HEX0: begin
              if (hx[4]) begin
                dval_next  = {5'b0, hx[3:0]};
                phase_next = PH_HEX1;
              end else begin
                raise = 1'b1;
              end
            end
            PH_HEX1: begin
              if (hx[4]) begin
                dlv   = 1'b1;
                dlv_v = {dval[3:0], hx[3:0]};
              end else begin
                flush = 1'b1;
                fv    = dval[7:0];
              end
            end
            PH_AFTER: begin
              in_after = 1'b1;
              ah       = held;
            end
            default: raise = 1'b1;
          endcase

          // A finished byte that does not look at the current character again.
          if (dlv) begin
            if (dash) begin
              cmd        = set_apply(base, held, dlv_v, 1'b0);
              phase_next = PH_IDLE;
              held_next  = '0;
              dash_next  = 1'b0;
            end else begin
              held_next  = dlv_v;
              phase_next = PH_AFTER;
              dash_next  = 1'b0;
            end
          end

          // A digit escape ended by a non-digit: finish it, then reparse.
          if (flush) begin
            if (dash) begin
              cmd     = set_apply(base, held, fv, 1'b0);
              in_idle = 1'b1;
              id_dash = 1'b0;
              id_held = '0;
            end else begin
              in_after = 1'b1;
              ah       = fv;
            end
          end

          if (in_after) begin
            if (c == CH_DASH) begin
              dash_next  = 1'b1;
              held_next  = ah;
              phase_next = PH_IDLE;
            end else begin
              cmd     = set_apply(base, ah, ah, 1'b0);
              in_idle = 1'b1;
              id_dash = 1'b0;
              id_held = '0;
            end
          end

          if (in_idle) begin
            if (c == CH_QUOTE) begin
              if (id_dash) begin
                cmd = set_apply(base, id_held, id_held, 1'b1);
              end
              cmd.status = ST_FINISHED;
              phase_next = PH_IDLE;
              held_next  = '0;
              dash_next  = 1'b0;
            end else if (c == CH_BSLASH) begin
              phase_next = PH_ESC;
              held_next  = id_held;
              dash_next  = id_dash;
            end else if (id_dash) begin
              cmd        = set_apply(base, id_held, c, 1'b0);
              phase_next = PH_IDLE;
              held_next  = '0;
              dash_next  = 1'b0;
            end else begin
              held_next  = c;
              phase_next = PH_AFTER;
              dash_next  = 1'b0;
            end
          end

          if (raise) begin
            cmd        = base;
            cmd.status = ST_INVALID;
            phase_next = PH_IDLE;
            held_next  = '0;
            dval_next  = '0;
            dcnt_next  = '0;
            dash_next  = 1'b0;
            err_next   = 1'b1;
          end
        end
      end

      MODE_EOL: begin
        phase_next = PH_IDLE;
        held_next  = '0;
        dval_next  = '0;
        dcnt_next  = '0;
        dash_next  = 1'b0;
        if (err) begin
          err_next = 1'b0;
        end else begin
          unique case (phase) inside
            PH_IDLE: begin
              if (dash) begin
                cmd = set_apply(base, held, held, 1'b1);
              end
            end
            PH_ESC: begin
              cmd = set_apply(base, dash ? held : CH_BSLASH, CH_BSLASH, 1'b0);
            end
            PH_OCT, PH_HEX1: begin
              cmd = set_apply(base, dash ? held : dval[7:0], dval[7:0], 1'b0);
            end
            PH_AFTER: begin
              cmd = set_apply(base, held, held, 1'b0);
            end
            default: cmd = base;
          endcase
        end
        // A bare \x at the end of the line is an invalid escape.
        cmd.status = (!err && phase == PH_HEX0) ? ST_INVALID : ST_FINISHED;
      end

      MODE_READ: cmd.kind = CMD_READ;
      MODE_EXCL: cmd.kind = CMD_EXCL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= '0;
      dval  <= '0;
      dcnt  <= '0;
      dash  <= 1'b0;
      err   <= 1'b0;
    end else if (acc) begin
      phase <= phase_next;
      held  <= held_next;
      dval  <= dval_next;
      dcnt  <= dcnt_next;
      dash  <= dash_next;
      err   <= err_next;
    end
  end

  // Raising an error always drops the parse back to the start of a byte.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    err |-> (phase == PH_IDLE) && !dash)
    else $error("error latch set with parse state pending");

endmodule

`default_nettype wire

// ===== src/cctb_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// cctb_cmd_queue: command queue between decoder and table engine
// A short register FIFO of command words.
// ----------------------------------------------------------------------------
`default_nettype none

module cctb_cmd_queue import cctb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t push_cmd,
  input  logic push_valid,
  output logic push_ready,
  output cmd_t pop_cmd,
  output logic pop_valid,
  input  logic pop_ready
);

  localparam logic [CMDQ_PTR_W-1:0] LAST_PTR = CMDQ_PTR_W'(CMDQ_DEPTH - 1);
  localparam logic [CMDQ_CNT_W-1:0] FULL_CNT = CMDQ_CNT_W'(CMDQ_DEPTH);

  cmd_t                  slots [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;
  logic                  do_push, do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("command queue holds more than its depth");

endmodule

`default_nettype wire

// ===== src/cctb_back.sv =====
// ----------------------------------------------------------------------------
// cctb_back: class table engine
// Holds the class table and carries out range updates, exclude walks and
// reads, one table entry per cycle, then presents the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cctb_back import cctb_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MASK_BITS     = MASK_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  cctb_out_if.source  result
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [CH_W:0]   TE_LIM = (CH_W + 1)'(TABLE_ENTRIES);
  localparam logic [CBIT_W:0] MB_LIM = (CBIT_W + 1)'(MASK_BITS);
  localparam logic [AW-1:0]   LAST_A = AW'(TABLE_ENTRIES - 1);
  localparam logic [AW-1:0]   DASH_A = AW'(CH_DASH);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_WALK  = 4'b0010,
    B_DRAIN = 4'b0100,
    B_READ  = 4'b1000
  } bstate_t;

  logic [MASK_BITS-1:0]     mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld;
  logic [MASK_BITS-1:0]     rd_data, rd_e, bitv, wd;
  logic                     rd_vld;
  logic [AW-1:0]            rd_addr;

  bstate_t                  state, state_next;
  logic [AW-1:0]            walk_addr, walk_addr_next, walk_end, walk_end_next;
  logic                     seg2, seg2_next;
  logic                     wb_pend, wb_next;
  logic [AW-1:0]            wb_addr;

  status_t                  cur_status;
  logic                     cur_excl, cur_rem;
  logic [CBIT_W-1:0]        cur_bit;
  logic [MASK_BITS-1:0]     cur_mask;

  logic                     res_valid;
  status_t                  res_status;
  logic [ENTRY_W-1:0]       res_entry;

  logic                     pop, load, fin, fin_read;
  status_t                  fin_status;
  logic                     lo_in, bit_ok;
  logic [AW-1:0]            hi_c;

  assign cmd_ready = (state == B_IDLE) && (!res_valid || result.ready);
  assign pop       = cmd_valid && cmd_ready;
  assign lo_in     = {1'b0, cmd.lo} < TE_LIM;
  assign bit_ok    = {1'b0, cmd.cbit} < MB_LIM;
  assign hi_c      = ({1'b0, cmd.hi} < TE_LIM) ? cmd.hi[AW-1:0] : LAST_A;

  always_comb begin
    state_next     = state;
    walk_addr_next = walk_addr;
    walk_end_next  = walk_end;
    seg2_next      = seg2;
    wb_next        = 1'b0;
    load           = 1'b0;
    fin            = 1'b0;
    fin_read       = 1'b0;
    fin_status     = cur_status;
    rd_addr        = walk_addr;
    unique case (state)
      B_IDLE: begin
        rd_addr = cmd.lo[AW-1:0];
        if (pop) begin
          load       = 1'b1;
          fin_status = cmd.status;
          unique case (cmd.kind)
            CMD_NONE: fin = 1'b1;
            CMD_READ: begin
              if (lo_in) state_next = B_READ;
              else       fin = 1'b1;
            end
            CMD_APPLY: begin
              if (!bit_ok) begin
                fin = 1'b1;
              end else if (lo_in) begin
                walk_addr_next = cmd.lo[AW-1:0];
                walk_end_next  = hi_c;
                seg2_next      = cmd.dash_too;
                state_next     = B_WALK;
              end else if (cmd.dash_too) begin
                walk_addr_next = DASH_A;
                walk_end_next  = DASH_A;
                seg2_next      = 1'b0;
                state_next     = B_WALK;
              end else begin
                fin = 1'b1;
              end
            end
            CMD_EXCL: begin
              if (!bit_ok) begin
                fin = 1'b1;
              end else begin
                walk_addr_next = '0;
                walk_end_next  = LAST_A;
                seg2_next      = 1'b0;
                state_next     = B_WALK;
              end
            end
          endcase
        end
      end
      B_WALK: begin
        wb_next = 1'b1;
        if (walk_addr == walk_end) state_next = B_DRAIN;
        else                       walk_addr_next = walk_addr + 1'b1;
      end
      B_DRAIN: begin
        if (seg2) begin
          walk_addr_next = DASH_A;
          walk_end_next  = DASH_A;
          seg2_next      = 1'b0;
          state_next     = B_WALK;
        end else begin
          fin        = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_READ: begin
        fin        = 1'b1;
        fin_read   = 1'b1;
        state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Entries never written since reset read as zero.
  assign rd_e = rd_vld ? rd_data : '0;
  assign bitv = {{(MASK_BITS - 1){1'b0}}, 1'b1} << cur_bit;

  always_comb begin
    if (cur_excl) begin
      wd = ((rd_e & cur_mask) != '0) ? (rd_e & ~bitv) : rd_e;
    end else if (cur_rem) begin
      wd = rd_e & ~bitv;
    end else begin
      wd = rd_e | bitv;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    rd_vld  <= vld[rd_addr];
    if (wb_pend) begin
      mem[wb_addr] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wb_pend) begin
      vld[wb_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr <= walk_addr;
    if (load) begin
      cur_status <= cmd.status;
      cur_excl   <= (cmd.kind == CMD_EXCL);
      cur_rem    <= cmd.rem;
      cur_bit    <= cmd.cbit;
      cur_mask   <= cmd.mask[MASK_BITS-1:0];
    end
    if (fin) begin
      res_status <= fin_status;
      res_entry  <= fin_read ? ENTRY_W'(rd_e) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      walk_addr <= '0;
      walk_end  <= '0;
      seg2      <= 1'b0;
      wb_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      walk_addr <= walk_addr_next;
      walk_end  <= walk_end_next;
      seg2      <= seg2_next;
      wb_pend   <= wb_next;
      if (fin) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign result.valid  = res_valid;
  assign result.status = res_status;
  assign result.entry  = res_entry;

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_WALK) |-> (walk_addr <= walk_end))
    else $error("range walk ran past its end entry");

  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (state == B_DRAIN) |=> !wb_pend)
    else $error("table write still pending after drain");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (state == B_READ) |=> result.valid)
    else $error("read finished without presenting a result");

endmodule

`default_nettype wire

// ===== src/char_class_table_builder.sv =====
// ----------------------------------------------------------------------------
// char_class_table_builder: character class bitmap table builder
// Answer path: a text byte or end of line with no table update passes the command
// queue and the result register; a read adds the table read; a range update walks
// its entries (and '-' for a trailing dash) and an exclude all TABLE_ENTRIES ones.
// Throughput: one item per cycle while no table work is pending and the result
// side is ready; each entry touched is one step of the read-modify-write walk.
// Reset clears the parser, the queue and the table's valid bits at once.
// ----------------------------------------------------------------------------
`default_nettype none

// The block builds a table of class masks, one per byte value. Set text
// comes in one raw byte per item and goes through a C escape decoder
// (simple escapes, one to three octal digits, \x with one or two hex
// digits). A decoded byte, a dash and another byte form an inclusive range,
// over which the class bit is set or cleared. Other items read one entry or
// exclude from the class every entry that overlaps another mask.
//
// The design is split in two halves joined by a short command queue:
//  - cctb_front decodes every item in the cycle of its transfer. It owns the
//    parse state (phase, held range start, gathered digits, dash and error
//    latch) and emits exactly one command per item. The command carries
//    the result status, which the decoder already knows, plus the table
//    work: a range to update (with an optional extra update of the '-'
//    entry for a trailing dash), a read, an exclude, or nothing.
//  - cctb_cmd_queue lets the decoder keep taking bytes while the engine is
//    busy walking a range.
//  - cctb_back owns the table memory. It runs each command to completion in
//    order, so a read always sees every earlier update. Updates are a
//    pipelined read-modify-write: one entry is read while the previous one
//    is written back, with a drain state at the end of each range so the
//    next command never reads an entry whose write is still in flight.
//    The result sits in an output register; the engine takes a new command
//    only when that register is empty or is being emptied in this cycle.
//
// Each table entry has a valid bit that reset clears; an entry whose bit is
// clear reads as zero, so no clearing pass is needed after reset.
module char_class_table_builder import cctb_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MASK_BITS     = MASK_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cctb_in_if.sink     item,
  cctb_out_if.source  result
);

  // Decoder to queue.
  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;

  // Queue to table engine.
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  cctb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  cctb_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_cmd    (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  cctb_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MASK_BITS     (MASK_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the character class table builder
// Streams set text, end-of-line, read and exclude items into the block with
// random idle gaps on both channels. Every accepted item is run through a
// local decoder and class table that track the block's state, and each
// result is checked field by field against the oldest outstanding reply.
// ----------------------------------------------------------------------------
module tb;
  import cctb_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  // An exclude walks all TABLE_ENTRIES entries; the tail
  // wait leaves room for one more of those before the verdict.
  localparam int TAIL_CYCLES  = 300;

  // Decoder phases of the set text parser.
  typedef enum logic [2:0] {
    DEC_IDLE,
    DEC_ESC,
    DEC_OCT,
    DEC_HEX_FIRST,
    DEC_HEX_SECOND,
    DEC_HELD
  } dec_phase_e;

  typedef struct {
    mode_t              mode;
    logic [CH_W-1:0]    ch;
    logic [CBIT_W-1:0]  cbit;
    logic               rem;
    logic [MASK_W-1:0]  mask;
  } set_item_t;

  typedef struct {
    status_t            status;
    logic [ENTRY_W-1:0] entry;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst;

  cctb_in_if  item_bus ();
  cctb_out_if result_bus ();

  char_class_table_builder i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Tracked state of the block: the class table and the escape decoder.
  // --------------------------------------------------------------------------
  logic [ENTRY_W-1:0] cls_tab [TABLE_ENTRIES_DEF];
  dec_phase_e         dec_phase;
  logic [7:0]         range_lo;
  logic [8:0]         digits;
  logic [1:0]         ndigits;
  logic               dash_held;
  logic               bad_latch;

  set_item_t    pending_items [$];
  table_reply_t due_replies [$];
  int           mismatches = 0;
  logic         item_taken = 1'b0;

  // Sets or clears one class bit over lo..hi. A reversed range collapses to
  // its start byte.
  function automatic void mark_range(input logic [7:0] lo, input logic [7:0] hi,
                                     input logic [CBIT_W-1:0] cbit, input logic rem);
    int i;
    int top;
    top = (hi < lo) ? int'(lo) : int'(hi);
    for (i = int'(lo); i <= top; i++)
      cls_tab[i][cbit] = ~rem;
  endfunction

  function automatic void clear_decoder();
    dec_phase = DEC_IDLE;
    range_lo  = '0;
    digits    = '0;
    ndigits   = '0;
    dash_held = 1'b0;
  endfunction

  // A fully decoded byte either becomes the held range start or, after a
  // dash, closes the range.
  function automatic void take_byte(input logic [7:0] b, input logic [CBIT_W-1:0] cbit,
                                    input logic rem);
    digits  = '0;
    ndigits = '0;
    if (!dash_held) begin
      range_lo  = b;
      dec_phase = DEC_HELD;
    end else begin
      mark_range(range_lo, b, cbit, rem);
      dash_held = 1'b0;
      range_lo  = '0;
      dec_phase = DEC_IDLE;
    end
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic status_t flag_bad_escape();
    clear_decoder();
    bad_latch = 1'b1;
    return ST_INVALID;
  endfunction

  // Flushes whatever is pending when the value ends (quote or end of line).
  // A dash with nothing after it is a literal: the held byte and '-' are
  // each marked alone.
  function automatic status_t close_value(input logic [CBIT_W-1:0] cbit, input logic rem);
    status_t st;
    logic    done;
    st   = ST_FINISHED;
    done = 1'b0;
    while (!done) begin
      case (dec_phase)
        DEC_ESC:                 take_byte(CH_BSLASH, cbit, rem);
        DEC_OCT, DEC_HEX_SECOND: take_byte(digits[7:0], cbit, rem);
        DEC_HEX_FIRST: begin
          clear_decoder();
          st   = ST_INVALID;
          done = 1'b1;
        end
        DEC_HELD: begin
          mark_range(range_lo, range_lo, cbit, rem);
          clear_decoder();
          done = 1'b1;
        end
        default: begin
          if (dash_held) begin
            mark_range(range_lo, range_lo, cbit, rem);
            mark_range(CH_DASH, CH_DASH, cbit, rem);
          end
          clear_decoder();
          done = 1'b1;
        end
      endcase
    end
    return st;
  endfunction

  // One raw text byte through the escape decoder. Some phases finish their
  // pending byte and then look at the same input again.
  function automatic status_t text_step(input logic [7:0] c, input logic [CBIT_W-1:0] cbit,
                                        input logic rem);
    status_t st;
    logic    done;
    int      h;
    st   = ST_ACCEPTED;
    done = 1'b0;
    if (bad_latch) begin
      st   = ST_INVALID;
      done = 1'b1;
    end
    while (!done) begin
      done = 1'b1;
      case (dec_phase)
        DEC_IDLE: begin
          if (c == CH_QUOTE)
            st = close_value(cbit, rem);
          else if (c == CH_BSLASH)
            dec_phase = DEC_ESC;
          else
            take_byte(c, cbit, rem);
        end
        DEC_ESC: begin
          case (c)
            CH_BSLASH: take_byte(CH_BSLASH, cbit, rem);
            "a":       take_byte(8'd7, cbit, rem);
            "b":       take_byte(8'd8, cbit, rem);
            "t":       take_byte(8'd9, cbit, rem);
            "n":       take_byte(8'd10, cbit, rem);
            "v":       take_byte(8'd11, cbit, rem);
            "f":       take_byte(8'd12, cbit, rem);
            "r":       take_byte(8'd13, cbit, rem);
            CH_QUOTE:  take_byte(CH_QUOTE, cbit, rem);
            "x", "X":  dec_phase = DEC_HEX_FIRST;
            default: begin
              if (c >= "0" && c <= "7") begin
                digits    = {6'd0, c[2:0]};
                ndigits   = 2'd1;
                dec_phase = DEC_OCT;
              end else begin
                st = flag_bad_escape();
              end
            end
          endcase
        end
        DEC_OCT: begin
          if (c >= "0" && c <= "7") begin
            digits  = {digits[5:0], c[2:0]};
            ndigits = ndigits + 2'd1;
            if (ndigits == 2'd3) begin
              if (digits > 9'd255)
                st = flag_bad_escape();
              else
                take_byte(digits[7:0], cbit, rem);
            end
          end else begin
            take_byte(digits[7:0], cbit, rem);
            done = 1'b0;
          end
        end
        DEC_HEX_FIRST: begin
          h = hex_digit(c);
          if (h < 0) begin
            st = flag_bad_escape();
          end else begin
            digits    = 9'(h);
            dec_phase = DEC_HEX_SECOND;
          end
        end
        DEC_HEX_SECOND: begin
          h = hex_digit(c);
          if (h >= 0) begin
            take_byte({digits[3:0], 4'(h)}, cbit, rem);
          end else begin
            take_byte(digits[7:0], cbit, rem);
            done = 1'b0;
          end
        end
        default: begin
          if (c == CH_DASH) begin
            dash_held = 1'b1;
            dec_phase = DEC_IDLE;
          end else begin
            // The held byte stands alone; re-examine c from idle.
            mark_range(range_lo, range_lo, cbit, rem);
            range_lo  = '0;
            dec_phase = DEC_IDLE;
            done      = 1'b0;
          end
        end
      endcase
    end
    return st;
  endfunction

  // Reply the block owes for one accepted item; updates the tracked state.
  function automatic table_reply_t builder_step(input set_item_t it);
    table_reply_t r;
    int           i;
    r.status = ST_ACCEPTED;
    r.entry  = '0;
    case (it.mode)
      MODE_TEXT: r.status = text_step(it.ch, it.cbit, it.rem);
      MODE_EOL: begin
        if (bad_latch) begin
          bad_latch = 1'b0;
          clear_decoder();
          r.status = ST_FINISHED;
        end else begin
          r.status = close_value(it.cbit, it.rem);
        end
      end
      MODE_READ: r.entry = cls_tab[it.ch];
      default: begin
        for (i = 0; i < TABLE_ENTRIES_DEF; i++)
          if ((cls_tab[i] & it.mask) != '0)
            cls_tab[i][it.cbit] = 1'b0;
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction.
  // --------------------------------------------------------------------------
  logic [CBIT_W-1:0] value_bit;
  logic              value_rem;
  logic              vary_bits = 1'b0;

  function automatic void queue_item(input mode_t m, input logic [7:0] c,
                                     input logic [CBIT_W-1:0] b, input logic r,
                                     input logic [MASK_W-1:0] msk);
    set_item_t it;
    it.mode = m;
    it.ch   = c;
    it.cbit = b;
    it.rem  = r;
    it.mask = msk;
    pending_items.push_back(it);
  endfunction

  function automatic logic [CBIT_W-1:0] rand_bit();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CBIT_W'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] rand_mask();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return MASK_W'(1) << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Text byte of the current value. The class bit and the set/clear choice
  // are taken at the byte that completes a range, so now and then a single
  // byte carries different ones to check that they are sampled there.
  function automatic void queue_byte(input logic [7:0] c);
    if (vary_bits && $urandom_range(0, 9) == 0)
      queue_item(MODE_TEXT, c, rand_bit(), 1'($urandom), rand_mask());
    else
      queue_item(MODE_TEXT, c, value_bit, value_rem, rand_mask());
  endfunction

  function automatic void queue_eol();
    queue_item(MODE_EOL, 8'($urandom), value_bit, value_rem, rand_mask());
  endfunction

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'("0" + v);
    return ($urandom_range(0, 1) != 0) ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] c);
    return c == CH_BSLASH || c == CH_QUOTE || c == "a" || c == "b" || c == "t" ||
           c == "n" || c == "v" || c == "f" || c == "r" || c == "x" || c == "X" ||
           (c >= "0" && c <= "7");
  endfunction

  // One element of set text: a plain byte, a dash, an escape of some kind,
  // a broken escape, or a read / exclude slipped into the middle of a value.
  function automatic void queue_piece();
    logic [7:0] c;
    int         k;
    int         n;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BSLASH);
      queue_byte(c);
    end else if (pick < 45) begin
      queue_byte(CH_DASH);
    end else if (pick < 60) begin
      k = $urandom_range(0, 8);
      queue_byte(CH_BSLASH);
      case (k)
        0:       queue_byte(CH_BSLASH);
        1:       queue_byte("a");
        2:       queue_byte("b");
        3:       queue_byte("t");
        4:       queue_byte("n");
        5:       queue_byte("v");
        6:       queue_byte("f");
        7:       queue_byte("r");
        default: queue_byte(CH_QUOTE);
      endcase
    end else if (pick < 75) begin
      // Octal: three digits starting at 4..7 overflow a byte.
      n = $urandom_range(1, 3);
      queue_byte(CH_BSLASH);
      if (n == 3 && $urandom_range(0, 3) == 0)
        queue_byte(8'("0" + $urandom_range(4, 7)));
      else
        queue_byte(8'("0" + $urandom_range(0, 3)));
      for (k = 1; k < n; k++)
        queue_byte(8'("0" + $urandom_range(0, 7)));
    end else if (pick < 88) begin
      queue_byte(CH_BSLASH);
      queue_byte(($urandom_range(0, 1) != 0) ? 8'("x") : 8'("X"));
      n = $urandom_range(1, 2);
      for (k = 0; k < n; k++)
        queue_byte(hex_char($urandom_range(0, 15)));
    end else if (pick < 92) begin
      queue_byte(CH_BSLASH);
      if ($urandom_range(0, 2) == 0) begin
        queue_byte("x");
        do c = 8'($urandom); while (hex_digit(c) >= 0);
      end else begin
        do c = 8'($urandom); while (is_escape_letter(c));
      end
      queue_byte(c);
    end else if (pick < 96) begin
      queue_item(MODE_READ, 8'($urandom), rand_bit(), 1'($urandom), rand_mask());
    end else begin
      queue_item(MODE_EXCL, 8'($urandom), rand_bit(), 1'($urandom), rand_mask());
    end
  endfunction

  // A whole value: a few elements, then a closing quote or an end of line.
  function automatic void queue_value();
    int k;
    int n;
    value_bit = rand_bit();
    value_rem = ($urandom_range(0, 3) == 0);
    n = $urandom_range(1, 8);
    for (k = 0; k < n; k++)
      queue_piece();
    case ($urandom_range(0, 9))
      0: begin
        // Lone backslash right before the end of line.
        queue_byte(CH_BSLASH);
        queue_eol();
      end
      1, 2, 3, 4, 5: begin
        queue_byte(CH_QUOTE);
        if ($urandom_range(0, 1) != 0)
          queue_eol();
      end
      default: queue_eol();
    endcase
  endfunction

  function automatic void queue_noise();
    int k;
    int n;
    n = $urandom_range(1, 4);
    for (k = 0; k < n; k++)
      queue_item(mode_t'($urandom_range(0, 3)), 8'($urandom), CBIT_W'($urandom),
                 1'($urandom), {$urandom, $urandom});
  endfunction

  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r == 0) begin
      quiet = $urandom_range(50, 200);
      return 0;
    end
    if (r < 120) return 0;
    if (r < 170) return $urandom_range(1, 3);
    if (r < 192) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: both channels change on the falling edge. A new item goes out
  // once the previous one was transferred and its idle gap has run down.
  // The result side holds ready low for random stretches.
  // --------------------------------------------------------------------------
  int send_wait  = 0;
  int send_quiet = 0;
  int hold_left  = 0;
  int hold_quiet = 0;

  always @(negedge clk) begin : drive_channels
    set_item_t nx;
    if (rst) begin
      item_bus.valid   <= 1'b0;
      result_bus.ready <= 1'b0;
    end else begin
      if (!item_bus.valid || item_taken) begin
        if (send_wait > 0) begin
          send_wait--;
          item_bus.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          nx = pending_items.pop_front();
          item_bus.valid       <= 1'b1;
          item_bus.mode        <= nx.mode;
          item_bus.ch          <= nx.ch;
          item_bus.class_bit   <= nx.cbit;
          item_bus.remove_bits <= nx.rem;
          item_bus.other_mask  <= nx.mask;
          send_wait = pick_gap(send_quiet);
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        hold_left = pick_gap(hold_quiet);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: on the rising edge, an item transfer feeds the tracked state and
  // queues the reply it owes; a result transfer is checked against the
  // oldest queued reply. Every item owes exactly one result, in order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    set_item_t    got;
    table_reply_t want;
    item_taken = 1'b0;
    if (!rst) begin
      if (item_bus.valid && item_bus.ready) begin
        item_taken = 1'b1;
        got.mode = mode_t'(item_bus.mode);
        got.ch   = item_bus.ch;
        got.cbit = item_bus.class_bit;
        got.rem  = item_bus.remove_bits;
        got.mask = item_bus.other_mask;
        due_replies.push_back(builder_step(got));
      end
      if (result_bus.valid && result_bus.ready) begin
        if (due_replies.size() == 0) begin
          $display("%0t: result with no item outstanding: expected none, actual status %0d entry %h",
                   $time, result_bus.status, result_bus.entry);
          mismatches++;
        end else begin
          want = due_replies.pop_front();
          if (result_bus.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, result_bus.status);
            mismatches++;
          end
          if (result_bus.entry !== want.entry) begin
            $display("%0t: entry mismatch: expected %h, actual %h",
                     $time, want.entry, result_bus.entry);
            mismatches++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence: reset, a directed set of values, then random values.
  // --------------------------------------------------------------------------
  initial begin : run_test
    int first_random;
    int k;
    rst                  = 1'b1;
    item_bus.valid       = 1'b0;
    item_bus.mode        = 2'd0;
    item_bus.ch          = '0;
    item_bus.class_bit   = '0;
    item_bus.remove_bits = 1'b0;
    item_bus.other_mask  = '0;
    result_bus.ready     = 1'b0;
    for (k = 0; k < TABLE_ENTRIES_DEF; k++)
      cls_tab[k] = '0;
    clear_decoder();
    bad_latch = 1'b0;

    // Hex escape \x5a ('Z'), a dash, then octal \101 ('A'): the range end is
    // below its start, so only 'Z' gets the top class bit.
    value_bit = 6'd63;
    value_rem = 1'b0;
    queue_byte(CH_BSLASH);
    queue_byte("x");
    queue_byte("5");
    queue_byte("a");
    queue_byte(CH_DASH);
    queue_byte(CH_BSLASH);
    queue_byte("1");
    queue_byte("0");
    queue_byte("1");
    // A plain range a..z.
    queue_byte("a");
    queue_byte(CH_DASH);
    queue_byte("z");
    // Top byte value alone, closed by the end of line, on class bit 0.
    value_bit = 6'd0;
    queue_byte(8'hFF);
    queue_eol();
    // Octal \400 overflows: the value is dropped until the end of line.
    queue_byte(CH_BSLASH);
    queue_byte("4");
    queue_byte("0");
    queue_byte("0");
    queue_byte(8'h00);
    queue_eol();
    // Backslash right at the end of line is a literal backslash.
    value_bit = 6'd5;
    queue_byte(CH_BSLASH);
    queue_eol();
    // Trailing dash before the quote: 'b' and '-' are marked, here cleared.
    value_rem = 1'b1;
    queue_byte("b");
    queue_byte(CH_DASH);
    queue_byte(CH_QUOTE);
    // \x with no hex digit before the end of line.
    queue_byte(CH_BSLASH);
    queue_byte("x");
    queue_eol();
    // Exclude on an all-ones mask, then read back the interesting entries.
    queue_item(MODE_EXCL, 8'h00, 6'd63, 1'b1, '1);
    queue_item(MODE_READ, "Z", 6'd0, 1'b0, '0);
    queue_item(MODE_READ, 8'hFF, 6'd63, 1'b1, '1);

    // Random part: mostly well-formed values, with reads, excludes and pure
    // noise mixed in between.
    vary_bits    = 1'b1;
    first_random = pending_items.size();
    while (pending_items.size() < first_random + RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0)
        queue_noise();
      else
        queue_value();
      if ($urandom_range(0, 9) < 3)
        for (k = $urandom_range(1, 3); k > 0; k--)
          queue_item(MODE_READ, 8'($urandom), rand_bit(), 1'($urandom), rand_mask());
      if ($urandom_range(0, 11) == 0)
        queue_item(MODE_EXCL, 8'($urandom), rand_bit(), 1'($urandom), rand_mask());
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pending_items.size() == 0 && !item_bus.valid && due_replies.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && due_replies.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #12000000;
    $display("%0t: timeout with %0d items unsent, %0d replies outstanding",
             $time, pending_items.size(), due_replies.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
